// ===== rtl/vvcrtp_pkg.sv =====
// ----------------------------------------------------------------------------
// vvcrtp_pkg
// Shared types and constants for the VVC RTP packetizer: RTP/FU header
// constants, configuration register indexes and the front-to-back command.
// ----------------------------------------------------------------------------
package vvcrtp_pkg;

    // Packet geometry
    localparam int unsigned DEF_MAX_PACKET_BYTES = 65535;
    localparam int unsigned MIN_PACKET_BYTES     = 16;
    localparam int unsigned HDR_BYTES            = 12;
    localparam int unsigned FU_HDR_BYTES         = 3;
    localparam int unsigned NAL_MIN_LEN          = 2;

    // Header field constants
    localparam logic [7:0] RTP_V2_BYTE     = 8'h80;
    localparam logic [4:0] FU_TYPE         = 5'd29;
    localparam logic [4:0] VCL_TYPE_LIMIT  = 5'd12;

    // Configuration reset values
    localparam logic [15:0] RST_MAX_PACKET_SIZE  = 16'd1400;
    localparam logic [6:0]  RST_PAYLOAD_TYPE     = 7'd96;
    localparam logic [15:0] RST_INITIAL_SEQUENCE = 16'd0;
    localparam logic [31:0] RST_SOURCE_ID        = 32'd0;

    // Command queue depth
    localparam int unsigned QUEUE_DEPTH = 4;

    // Byte positions inside one command; 0..11 are the RTP header
    localparam logic [3:0] POS_PRE0 = 4'd12;
    localparam logic [3:0] POS_PRE1 = 4'd13;
    localparam logic [3:0] POS_PRE2 = 4'd14;
    localparam logic [3:0] POS_DATA = 4'd15;

    typedef enum logic [1:0] {
        CFG_MAX_PACKET_SIZE  = 2'd0,
        CFG_PAYLOAD_TYPE     = 2'd1,
        CFG_INITIAL_SEQUENCE = 2'd2,
        CFG_SOURCE_ID        = 2'd3
    } cfg_idx_t;

    // Sequence counter load from the configuration port
    typedef struct packed {
        logic        load;
        logic [15:0] value;
    } seq_load_t;

    // One packetizing command: optional RTP header, prefix bytes, one data byte
    typedef struct packed {
        logic        hdr;     // emit 12-byte RTP header first
        logic        fu;      // three prefix bytes instead of one
        logic        marker;
        logic [15:0] seq;
        logic [31:0] ts;
        logic [7:0]  pre0;
        logic [7:0]  pre1;
        logic [7:0]  pre2;
        logic [7:0]  data;
        logic        last;    // data byte ends the packet
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// ===== rtl/vvcrtp_front.sv =====
// ----------------------------------------------------------------------------
// vvcrtp_front
// Accepts NAL bytes, tracks NAL/fragment state and the sequence counter, and
// issues one packetizing command per byte that produces output.
// ----------------------------------------------------------------------------
module vvcrtp_front #(
    parameter int unsigned MAX_PACKET_BYTES = vvcrtp_pkg::DEF_MAX_PACKET_BYTES
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [7:0]            in_byte,
    input  logic                  nal_start,
    input  logic [15:0]           nal_length,
    input  logic                  end_of_access_unit,
    input  logic [31:0]           timestamp,
    input  logic                  q_full,
    input  logic [15:0]           max_packet_size,
    input  vvcrtp_pkg::seq_load_t seq_load,
    output logic                  push,
    output vvcrtp_pkg::cmd_t      cmd
);
    import vvcrtp_pkg::*;

    localparam logic [15:0] MAX_SZ  = 16'(MAX_PACKET_BYTES);
    localparam logic [15:0] MIN_SZ  = 16'(MIN_PACKET_BYTES);
    localparam logic [15:0] FU_OVH  = 16'(HDR_BYTES + FU_HDR_BYTES);

    logic [15:0] seq_reg, seq_next;
    logic [15:0] held_reg, held_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] fill_reg, fill_next;
    logic        fmode_reg, fmode_next;
    logic        first_reg, first_next;
    logic [31:0] time_reg, time_next;
    logic        mark_reg, mark_next;
    logic        tp_reg, tp_next;

    logic        accept;
    logic [15:0] sz;
    logic [15:0] rem_dec;
    logic [15:0] cap;
    logic [15:0] fill_inc;
    logic        frag_start;
    logic        final_frag;
    logic        nal_done;
    logic        frag_last;

    assign accept = in_valid && !q_full;

    // Effective packet size, clamped to the supported range
    always_comb
    begin
        if (max_packet_size < MIN_SZ)
            sz = MIN_SZ;
        else if (max_packet_size > MAX_SZ)
            sz = MAX_SZ;
        else
            sz = max_packet_size;
    end

    // Size decisions
    assign rem_dec    = rem_reg - 16'd1;
    assign nal_done   = (rem_dec == 16'd0);
    assign cap        = sz - FU_OVH;
    assign fill_inc   = fill_reg + 16'd1;
    assign frag_start = ({1'b0, nal_length} + 17'(HDR_BYTES)) > {1'b0, sz};
    assign final_frag = ({1'b0, rem_dec} + 17'(HDR_BYTES + FU_HDR_BYTES + 1))
                        <= {1'b0, sz};
    assign frag_last  = (fill_inc >= cap) || nal_done;

    // Per-byte state update and command build
    always_comb
    begin
        seq_next   = seq_reg;
        held_next  = held_reg;
        rem_next   = rem_reg;
        fill_next  = fill_reg;
        fmode_next = fmode_reg;
        first_next = first_reg;
        time_next  = time_reg;
        mark_next  = mark_reg;
        tp_next    = tp_reg;
        push       = 1'b0;

        cmd.hdr    = 1'b0;
        cmd.fu     = 1'b0;
        cmd.marker = 1'b0;
        cmd.seq    = seq_reg;
        cmd.ts     = time_reg;
        cmd.pre0   = held_reg[15:8];
        cmd.pre1   = {FU_TYPE, held_reg[2:0]};
        cmd.pre2   = {first_reg, final_frag, final_frag & mark_reg, held_reg[7:3]};
        cmd.data   = in_byte;
        cmd.last   = nal_done;

        if (accept)
        begin
            if (rem_reg == 16'd0)
            begin
                // idle: open a NAL on a valid start byte
                if (nal_start && (nal_length >= 16'(NAL_MIN_LEN)))
                begin
                    time_next  = timestamp;
                    mark_next  = end_of_access_unit;
                    held_next  = {in_byte, 8'h00};
                    rem_next   = nal_length - 16'd1;
                    fmode_next = frag_start;
                    first_next = 1'b1;
                    fill_next  = 16'd0;
                    tp_next    = 1'b1;
                end
            end
            else
            begin
                rem_next = rem_dec;
                if (tp_reg)
                begin
                    // second NAL header byte: type known now
                    tp_next   = 1'b0;
                    held_next = {held_reg[15:8], in_byte};
                    if (!fmode_reg)
                    begin
                        push       = 1'b1;
                        cmd.hdr    = 1'b1;
                        cmd.marker = (in_byte[7:3] < VCL_TYPE_LIMIT) && mark_reg;
                        if (nal_done)
                            seq_next = seq_reg + 16'd1;
                    end
                end
                else if (!fmode_reg)
                begin
                    push = 1'b1;
                    if (nal_done)
                        seq_next = seq_reg + 16'd1;
                end
                else
                begin
                    // fragmentation unit payload byte
                    push       = 1'b1;
                    cmd.fu     = 1'b1;
                    cmd.hdr    = (fill_reg == 16'd0);
                    cmd.marker = final_frag && mark_reg;
                    cmd.last   = frag_last;
                    if (fill_reg == 16'd0)
                        first_next = 1'b0;
                    if (frag_last)
                    begin
                        fill_next = 16'd0;
                        seq_next  = seq_reg + 16'd1;
                    end
                    else
                    begin
                        fill_next = fill_inc;
                    end
                end
            end
        end

        if (seq_load.load)
            seq_next = seq_load.value;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg   <= RST_INITIAL_SEQUENCE;
            held_reg  <= 16'd0;
            rem_reg   <= 16'd0;
            fill_reg  <= 16'd0;
            fmode_reg <= 1'b0;
            first_reg <= 1'b1;
            time_reg  <= 32'd0;
            mark_reg  <= 1'b0;
            tp_reg    <= 1'b0;
        end
        else
        begin
            seq_reg   <= seq_next;
            held_reg  <= held_next;
            rem_reg   <= rem_next;
            fill_reg  <= fill_next;
            fmode_reg <= fmode_next;
            first_reg <= first_next;
            time_reg  <= time_next;
            mark_reg  <= mark_next;
            tp_reg    <= tp_next;
        end
    end

endmodule

// ===== rtl/vvcrtp_fifo.sv =====
// ----------------------------------------------------------------------------
// vvcrtp_fifo
// Short command queue between the front and back stages.
// ----------------------------------------------------------------------------
module vvcrtp_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  vvcrtp_pkg::cmd_t    wdata,
    input  logic                pop,
    output vvcrtp_pkg::cmd_t    rdata,
    output vvcrtp_pkg::q_stat_t stat
);
    import vvcrtp_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    cmd_t          mem_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign stat.full  = (count_reg == CW'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign rdata      = mem_reg[rd_ptr_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= wdata;
    end

endmodule

// ===== rtl/vvcrtp_back.sv =====
// ----------------------------------------------------------------------------
// vvcrtp_back
// Expands queued commands into RTP packet bytes, one byte per cycle while the
// output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module vvcrtp_back (
    input  logic                clk,
    input  logic                rst_n,
    input  vvcrtp_pkg::cmd_t    rdata,
    input  vvcrtp_pkg::q_stat_t stat,
    input  logic [6:0]          payload_type,
    input  logic [31:0]         source_id,
    input  logic                out_stall,
    output logic                pop,
    output logic                out_valid,
    output logic [7:0]          out_byte,
    output logic                packet_last
);
    import vvcrtp_pkg::*;

    cmd_t       cur_reg, cur_next;
    logic       cur_valid_reg, cur_valid_next;
    logic [3:0] pos_reg, pos_next;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic       packet_last_reg;

    logic       out_free;
    logic       advance;
    logic       at_data;
    logic [7:0] sel_byte;

    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = cur_valid_reg && out_free;
    assign at_data  = (pos_reg == POS_DATA);
    assign pop      = (!cur_valid_reg || (advance && at_data)) && !stat.empty;

    // Byte at the current position
    always_comb
    begin
        case (pos_reg)
            4'd0:    sel_byte = RTP_V2_BYTE;
            4'd1:    sel_byte = {cur_reg.marker, payload_type};
            4'd2:    sel_byte = cur_reg.seq[15:8];
            4'd3:    sel_byte = cur_reg.seq[7:0];
            4'd4:    sel_byte = cur_reg.ts[31:24];
            4'd5:    sel_byte = cur_reg.ts[23:16];
            4'd6:    sel_byte = cur_reg.ts[15:8];
            4'd7:    sel_byte = cur_reg.ts[7:0];
            4'd8:    sel_byte = source_id[31:24];
            4'd9:    sel_byte = source_id[23:16];
            4'd10:   sel_byte = source_id[15:8];
            4'd11:   sel_byte = source_id[7:0];
            POS_PRE0: sel_byte = cur_reg.pre0;
            POS_PRE1: sel_byte = cur_reg.pre1;
            POS_PRE2: sel_byte = cur_reg.pre2;
            default: sel_byte = cur_reg.data;
        endcase
    end

    // Command walk: load from queue, step position
    always_comb
    begin
        cur_next       = cur_reg;
        cur_valid_next = cur_valid_reg;
        pos_next       = pos_reg;
        if (pop)
        begin
            cur_next       = rdata;
            cur_valid_next = 1'b1;
            pos_next       = rdata.hdr ? 4'd0 : POS_DATA;
        end
        else if (advance)
        begin
            if (at_data)
                cur_valid_next = 1'b0;
            else if ((pos_reg == POS_PRE0) && !cur_reg.fu)
                pos_next = POS_DATA;
            else
                pos_next = pos_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            pos_reg       <= POS_DATA;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            pos_reg       <= pos_next;
            if (out_free)
                out_valid_reg <= advance;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (out_free)
        begin
            out_byte_reg    <= sel_byte;
            packet_last_reg <= at_data && cur_reg.last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_byte    = out_byte_reg;
    assign packet_last = packet_last_reg;

endmodule

// ===== rtl/vvc_rtp_packetizer.sv =====
// ----------------------------------------------------------------------------
// vvc_rtp_packetizer
// RTP packetizer for H.266/VVC NAL units: single NAL unit packets and
// fragmentation units, one NAL byte in, RTP packet bytes out.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in      | sink      | in_valid / in_stall | in_byte, nal_start, nal_length,
//          |           |                     | end_of_access_unit, timestamp
//  out     | source    | out_valid/out_stall | out_byte, packet_last
//  cfg     | sink      | cfg_we              | cfg_addr, cfg_data
//
//  Each NAL byte that produces output becomes one command in a 4-entry queue;
//  the back stage emits one output byte per cycle while out_stall is low, so a
//  plain payload byte yields one byte and a packet start 14 (single NAL) or 16
//  (FU) bytes. in_stall rises only when the command queue is full, e.g. during
//  header bursts or while the output is stalled.
//  rst_n clears all control state and loads the register reset values.
// ----------------------------------------------------------------------------
module vvc_rtp_packetizer #(
    parameter int unsigned MAX_PACKET_BYTES = vvcrtp_pkg::DEF_MAX_PACKET_BYTES
) (
    input  logic        clk,
    input  logic        rst_n,
    // configuration
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_data,
    // NAL byte input
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    input  logic        nal_start,
    input  logic [15:0] nal_length,
    input  logic        end_of_access_unit,
    input  logic [31:0] timestamp,
    // RTP byte output
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_byte,
    output logic        packet_last
);
    import vvcrtp_pkg::*;

    logic [15:0] max_packet_size_reg;
    logic [6:0]  payload_type_reg;
    logic [31:0] source_id_reg;
    seq_load_t   seq_load;

    logic        push;
    logic        pop;
    cmd_t        wcmd;
    cmd_t        rcmd;
    q_stat_t     qstat;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_packet_size_reg <= RST_MAX_PACKET_SIZE;
            payload_type_reg    <= RST_PAYLOAD_TYPE;
            source_id_reg       <= RST_SOURCE_ID;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_MAX_PACKET_SIZE:  max_packet_size_reg <= cfg_data[15:0];
                CFG_PAYLOAD_TYPE:     payload_type_reg    <= cfg_data[6:0];
                CFG_INITIAL_SEQUENCE: ;
                CFG_SOURCE_ID:        source_id_reg       <= cfg_data;
            endcase
        end
    end

    // Sequence counter load lives in the front stage
    assign seq_load.load  = cfg_we && (cfg_idx_t'(cfg_addr) == CFG_INITIAL_SEQUENCE);
    assign seq_load.value = cfg_data[15:0];

    assign in_stall = qstat.full;

    vvcrtp_front #(
        .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
    ) u_front (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_byte            (in_byte),
        .nal_start          (nal_start),
        .nal_length         (nal_length),
        .end_of_access_unit (end_of_access_unit),
        .timestamp          (timestamp),
        .q_full             (qstat.full),
        .max_packet_size    (max_packet_size_reg),
        .seq_load           (seq_load),
        .push               (push),
        .cmd                (wcmd)
    );

    vvcrtp_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (wcmd),
        .pop   (pop),
        .rdata (rcmd),
        .stat  (qstat)
    );

    vvcrtp_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rdata        (rcmd),
        .stat         (qstat),
        .payload_type (payload_type_reg),
        .source_id    (source_id_reg),
        .out_stall    (out_stall),
        .pop          (pop),
        .out_valid    (out_valid),
        .out_byte     (out_byte),
        .packet_last  (packet_last)
    );

endmodule

// ===== rtl/vvcrtp_checker.sv =====
// ----------------------------------------------------------------------------
// vvcrtp_checker
// Port-level checks on the VVC RTP packetizer, bound to the top level.
// ----------------------------------------------------------------------------
module vvcrtp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_stall,
    input logic       out_valid,
    input logic       out_stall,
    input logic [7:0] out_byte,
    input logic       packet_last
);
    import vvcrtp_pkg::*;

    logic pkt_start_reg;

    // Track whether the next output byte opens a packet
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pkt_start_reg <= 1'b1;
        else if (out_valid && !out_stall)
            pkt_start_reg <= packet_last;
    end

    // Reset leaves both channels quiet
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> (!out_valid && !in_stall))
        else $error("outputs active during reset");

    // A stalled output item holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(out_byte) && $stable(packet_last)))
        else $error("stalled output item changed");

    // Every packet opens with the RTP version byte
    a_pkt_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pkt_start_reg) |-> (out_byte == RTP_V2_BYTE))
        else $error("packet does not start with RTP version byte");

    // Input backpressure only while output is backed up
    a_stall_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with no output pending");

endmodule

bind vvc_rtp_packetizer vvcrtp_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_byte    (out_byte),
    .packet_last (packet_last)
);
